// File: rtl/bga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_pkg
// Shared constants, codes and helpers for the battery gauge averager.
// ----------------------------------------------------------------------------
package bga_pkg;

    // Field widths
    localparam int RAW_W   = 14;
    localparam int MV_W    = 15;
    localparam int LIM_W   = 13;
    localparam int LVL_W   = 7;
    localparam int PCT_W   = 7;
    localparam int BST_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Ring depth default
    localparam int RING_DEPTH_DEF = 8;

    // raw_sum * 1126 needs 25 bits
    localparam int SCALE_W = 25;

    // Arithmetic constants
    localparam logic [10:0] SCALE_MUL   = 11'd1126;
    localparam logic [9:0]  SCALE_DIV   = 10'd1000;
    localparam logic [6:0]  PCT_DIV     = 7'd100;
    localparam logic [6:0]  LEVEL_FULL  = 7'd100;
    localparam logic [MV_W-1:0] CHG_LIMIT_MV = 15'd4226;
    localparam logic [MV_W-1:0] CHG_STEP0_MV = 15'd4100;
    localparam logic [MV_W-1:0] CHG_STEP1_MV = 15'd4200;
    localparam logic [MV_W-1:0] CHG_STEP2_MV = 15'd4210;

    // Reciprocals for the constant divisions: x / 1000 == (x * RCP1000) >> 35
    // for any 25-bit x, and x / 100 == (x * RCP100) >> 26 for x below 2^19
    localparam int RCP1000_W  = 26;
    localparam int RCP1000_SH = 35;
    localparam logic [RCP1000_W-1:0] RCP1000 = 26'd34359739;
    localparam int RCP100_W   = 20;
    localparam int RCP100_SH  = 26;
    localparam logic [RCP100_W-1:0]  RCP100  = 20'd671089;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_EMPTY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_FULL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK   = 2'd2;

    // Configuration reset values
    localparam logic [LIM_W-1:0] VOLT_EMPTY_RST = 13'd3500;
    localparam logic [LIM_W-1:0] VOLT_FULL_RST  = 13'd4150;
    localparam logic [LVL_W-1:0] LOW_MARK_RST   = 7'd10;

    // Battery state codes
    localparam logic [BST_W-1:0] BST_NORMAL   = 2'd0;
    localparam logic [BST_W-1:0] BST_LOW      = 2'd1;
    localparam logic [BST_W-1:0] BST_CHARGING = 2'd2;
    localparam logic [BST_W-1:0] BST_FULL     = 2'd3;

    // Divider status between the divider and the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Stepped charge percentage
    function automatic logic [PCT_W-1:0] charge_pct(input logic [MV_W-1:0] mv);
        logic [PCT_W-1:0] pct;
        if (mv < CHG_STEP0_MV)
        begin
            pct = 7'd96;
        end
        else if (mv < CHG_STEP1_MV)
        begin
            pct = 7'd97;
        end
        else if (mv < CHG_STEP2_MV)
        begin
            pct = 7'd98;
        end
        else
        begin
            pct = 7'd99;
        end
        return pct;
    endfunction

endpackage

// File: rtl/bga_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_ring
// Sample ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bga_ring
    import bga_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF,
    parameter int IDX_W = 3
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [MV_W-1:0]  wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [MV_W-1:0]  rdata
);

    logic [MV_W-1:0] mem [DEPTH];
    logic [MV_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bga_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bga_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bga_div
    import bga_pkg::*;
#(
    parameter int DW = SCALE_W,
    parameter int VW = LIM_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output div_stat_t     stat
);

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          done_reg;
    logic          done_next;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] quo_next;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] rem_next;
    logic [VW-1:0] dvs_reg;
    logic [VW-1:0] dvs_next;
    logic [VW:0]   shifted;
    logic          fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        fits      = (shifted >= {1'b0, dvs_reg});
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start)
        begin
            // Load operands, clear partial remainder
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // Shift one dividend bit in, subtract when it fits
            rem_next  = fits ? VW'(shifted - {1'b0, dvs_reg}) : shifted[VW-1:0];
            quo_next  = {quo_reg[DW-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

// File: rtl/battery_gauge_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_gauge_average
// Battery voltage moving-average gauge with level and state classification.
// ----------------------------------------------------------------------------
// One poll transaction carries the summed converter reading and the charger
// flag; one result transaction follows with the averaged voltage, a 0..100
// level and the battery state. The block works on one poll at a time and
// holds in_stall high from acceptance until the result is loaded into the
// output register; the next poll may enter while that result still waits.
// in_stall drops at the same edge that loads the result. The millivolt
// scaling and the charge percentage each form a registered product, then
// apply a constant reciprocal multiply in place of the division; the
// charging correction and the level division run only when they apply.
// The shared bit-serial divider, 20 bits wide at the default depth, forms
// the average and the level, and the ring memory's one read port is swept
// one entry at a time, through a read state and an accumulate state, to
// form the sum of the N filled entries (up to RING_DEPTH). Ring entries
// are only ever read after they were written, so the ring needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module battery_gauge_average
    import bga_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // poll channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [RAW_W-1:0]     raw_sum,
    input  logic                 charger_present,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [MV_W-1:0]      avg_mv,
    output logic [LVL_W-1:0]     level_pct,
    output logic [BST_W-1:0]     batt_state
);

    // Derived widths
    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = MV_W + CNT_W;
    localparam int LVN_W = LIM_W + LVL_W;
    localparam int DIV_W = (SUM_W > LVN_W) ? SUM_W : LVN_W;
    localparam int DVS_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int SCF_W = SCALE_W + RCP1000_W;
    localparam int CHF_W = SCALE_W + RCP100_W;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCALE   = 4'd1;
    localparam logic [3:0] S_SCALE_W = 4'd2;
    localparam logic [3:0] S_CHG     = 4'd3;
    localparam logic [3:0] S_CHG_W   = 4'd4;
    localparam logic [3:0] S_WRITE   = 4'd5;
    localparam logic [3:0] S_READ    = 4'd6;
    localparam logic [3:0] S_ACC     = 4'd7;
    localparam logic [3:0] S_AVG_W   = 4'd8;
    localparam logic [3:0] S_LEVEL   = 4'd9;
    localparam logic [3:0] S_LEVEL_W = 4'd10;
    localparam logic [3:0] S_FINISH  = 4'd11;

    // Control state
    logic [3:0]       state_reg,       state_next;
    logic [IDX_W-1:0] write_slot_reg,  write_slot_next;
    logic [CNT_W-1:0] valid_count_reg, valid_count_next;
    logic [IDX_W-1:0] rd_idx_reg,      rd_idx_next;
    logic [MV_W-1:0]  last_avg_reg,    last_avg_next;
    logic [BST_W-1:0] last_state_reg,  last_state_next;
    logic             out_valid_reg,   out_valid_next;

    // Configuration
    logic [LIM_W-1:0] volt_empty_reg;
    logic [LIM_W-1:0] volt_full_reg;
    logic [LVL_W-1:0] low_mark_reg;

    // Working payload
    logic [RAW_W-1:0]   raw_reg,       raw_next;
    logic               chg_reg,       chg_next;
    logic [SCALE_W-1:0] prod_reg,      prod_next;
    logic [MV_W-1:0]    mv_reg,        mv_next;
    logic [SUM_W-1:0]   sum_reg,       sum_next;
    logic [MV_W-1:0]    avg_reg,       avg_next;
    logic [LVL_W-1:0]   level_reg,     level_next;
    logic [MV_W-1:0]    out_avg_reg,   out_avg_next;
    logic [LVL_W-1:0]   out_level_reg, out_level_next;
    logic [BST_W-1:0]   out_bst_reg,   out_bst_next;

    // Divider hookup
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic [DIV_W-1:0] div_quo;
    div_stat_t        div_stat;

    // Ring hookup
    logic             ring_we;
    logic             ring_re;
    logic [MV_W-1:0]  ring_rdata;

    logic             in_accept;
    logic             out_free;
    logic [MV_W-1:0]  quo_mv;
    logic [LIM_W-1:0] span_mv;
    logic [LIM_W-1:0] above_empty;
    logic [BST_W-1:0] new_bst;
    logic [SCF_W-1:0] scale_full;
    logic [MV_W-1:0]  scale_mv;
    logic [CHF_W-1:0] chg_full;
    logic [MV_W-1:0]  chg_mv;

    bga_div #(
        .DW (DIV_W),
        .VW (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    bga_ring #(
        .DEPTH (RING_DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (write_slot_reg),
        .wdata (mv_reg),
        .re    (ring_re),
        .raddr (rd_idx_reg),
        .rdata (ring_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign quo_mv    = div_quo[MV_W-1:0];
    // Only used where volt_empty < avg < volt_full, so both fit 13 bits
    assign span_mv     = volt_full_reg - volt_empty_reg;
    assign above_empty = avg_reg[LIM_W-1:0] - volt_empty_reg;

    // Divide the registered product by 1000 or by 100 with a reciprocal multiply
    assign scale_full = SCF_W'(prod_reg) * SCF_W'(RCP1000);
    assign scale_mv   = scale_full[RCP1000_SH +: MV_W];
    assign chg_full   = CHF_W'(prod_reg) * CHF_W'(RCP100);
    assign chg_mv     = chg_full[RCP100_SH +: MV_W];

    assign ring_we = (state_reg == S_WRITE);
    assign ring_re = (state_reg == S_READ);

    // Classify the state from the finished level
    always_comb
    begin
        if (chg_reg)
        begin
            new_bst = (level_reg < LEVEL_FULL) ? BST_CHARGING : BST_FULL;
        end
        else
        begin
            new_bst = (level_reg > low_mark_reg) ? BST_NORMAL : BST_LOW;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        write_slot_next  = write_slot_reg;
        valid_count_next = valid_count_reg;
        rd_idx_next      = rd_idx_reg;
        last_avg_next    = last_avg_reg;
        last_state_next  = last_state_reg;
        out_valid_next   = out_valid_reg;
        raw_next         = raw_reg;
        chg_next         = chg_reg;
        prod_next        = prod_reg;
        mv_next          = mv_reg;
        sum_next         = sum_reg;
        avg_next         = avg_reg;
        level_next       = level_reg;
        out_avg_next     = out_avg_reg;
        out_level_next   = out_level_reg;
        out_bst_next     = out_bst_reg;
        div_start        = 1'b0;
        div_dividend     = '0;
        div_divisor      = '0;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    raw_next   = raw_sum;
                    chg_next   = charger_present;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                // Millivolts = raw_sum * 1126 / 1000; form the product first
                prod_next  = SCALE_W'(raw_reg) * SCALE_W'(SCALE_MUL);
                state_next = S_SCALE_W;
            end
            S_SCALE_W:
            begin
                mv_next = scale_mv;
                if (chg_reg && (scale_mv < CHG_LIMIT_MV) &&
                    (last_state_reg != BST_FULL))
                begin
                    state_next = S_CHG;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_CHG:
            begin
                prod_next  = SCALE_W'(mv_reg) * SCALE_W'(charge_pct(mv_reg));
                state_next = S_CHG_W;
            end
            S_CHG_W:
            begin
                // Never let the charging value fall below the last average
                mv_next    = (chg_mv < last_avg_reg) ? last_avg_reg : chg_mv;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // Store the sample, advance the slot, start the sum sweep
                write_slot_next = (write_slot_reg == IDX_W'(RING_DEPTH - 1)) ?
                                  '0 : write_slot_reg + 1'b1;
                if (valid_count_reg != CNT_W'(RING_DEPTH))
                begin
                    valid_count_next = valid_count_reg + 1'b1;
                end
                rd_idx_next = '0;
                sum_next    = '0;
                state_next  = S_READ;
            end
            S_READ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sum_next = sum_reg + SUM_W'(ring_rdata);
                if (CNT_W'(rd_idx_reg) == valid_count_reg - 1'b1)
                begin
                    state_next = S_AVG_W;
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(sum_reg + SUM_W'(ring_rdata));
                    div_divisor  = DVS_W'(valid_count_reg);
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = S_READ;
                end
            end
            S_AVG_W:
            begin
                if (div_stat.done)
                begin
                    avg_next      = quo_mv;
                    last_avg_next = quo_mv;
                    state_next    = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                if (avg_reg <= MV_W'(volt_empty_reg))
                begin
                    level_next = '0;
                    state_next = S_FINISH;
                end
                else if (avg_reg >= MV_W'(volt_full_reg))
                begin
                    level_next = LEVEL_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(above_empty) * DIV_W'(LEVEL_FULL);
                    div_divisor  = DVS_W'(span_mv);
                    state_next   = S_LEVEL_W;
                end
            end
            S_LEVEL_W:
            begin
                if (div_stat.done)
                begin
                    level_next = div_quo[LVL_W-1:0];
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_avg_next    = avg_reg;
                    out_level_next  = level_reg;
                    out_bst_next    = new_bst;
                    last_state_next = new_bst;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_slot_reg  <= '0;
            valid_count_reg <= '0;
            rd_idx_reg      <= '0;
            last_avg_reg    <= '0;
            last_state_reg  <= BST_NORMAL;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            valid_count_reg <= valid_count_next;
            rd_idx_reg      <= rd_idx_next;
            last_avg_reg    <= last_avg_next;
            last_state_reg  <= last_state_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_empty_reg <= VOLT_EMPTY_RST;
            volt_full_reg  <= VOLT_FULL_RST;
            low_mark_reg   <= LOW_MARK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VOLT_EMPTY: volt_empty_reg <= cfg_wdata[LIM_W-1:0];
                CFG_VOLT_FULL:  volt_full_reg  <= cfg_wdata[LIM_W-1:0];
                CFG_LOW_MARK:   low_mark_reg   <= cfg_wdata[LVL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        chg_reg       <= chg_next;
        prod_reg      <= prod_next;
        mv_reg        <= mv_next;
        sum_reg       <= sum_next;
        avg_reg       <= avg_next;
        level_reg     <= level_next;
        out_avg_reg   <= out_avg_next;
        out_level_reg <= out_level_next;
        out_bst_reg   <= out_bst_next;
    end

    assign out_valid  = out_valid_reg;
    assign avg_mv     = out_avg_reg;
    assign level_pct  = out_level_reg;
    assign batt_state = out_bst_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result loaded outside finish");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_count_reg <= CNT_W'(RING_DEPTH))
        else $error("valid count beyond ring depth");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level_pct <= LEVEL_FULL))
        else $error("level above one hundred");

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (in_stall && !$rose(out_valid)))
        else $error("poll not held in progress");

endmodule
